// ----- rtl/core/efs_pkg.sv -----
// Package for the earliest-free server scheduler.
// Holds sizes, request codes and the sequencer state type; no dependencies.
package efs_pkg;

  localparam int unsigned MaxServers = 16;
  localparam int unsigned TimeBits   = 40;
  localparam int unsigned IdxBits    = $clog2(MaxServers);
  localparam int unsigned CntBits    = $clog2(MaxServers + 1);
  localparam int unsigned RateBits   = 8;
  localparam int unsigned ItemBits   = 8;
  localparam int unsigned WorkBits   = RateBits + ItemBits;
  localparam int unsigned CfgBits    = 5;

  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 128;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_JOB   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_UPDATE
  } state_e;

endpackage

// ----- rtl/core/earliest_free_server_scheduler.sv -----
// Earliest-free server scheduler top level; depends on efs_pkg.
// Sequence: a job transfer starts a scan of the N active servers (one compare
//   per scan cycle), then ST_MUL, ST_ADD and ST_UPDATE register the result.
// Ready only in ST_IDLE: no new request while a job runs or the result stalls.
// Reset (rst_ni low, asynchronous): free times and makespan read as zero,
//   server count is 1, rates stay undefined until loaded.
module earliest_free_server_scheduler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [efs_pkg::CfgBits-1:0]       cfg_wdata_i,    // server_count
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [3:0] server_index, [11:4] unit_rate, [19:12] item_count, [23:20] zero
  input  logic [efs_pkg::InDataBits-1:0]    s_axis_tdata_i,
  input  logic [1:0]                        s_axis_tuser_i, // req_type
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [3:0] chosen_server, [43:4] start_time, [83:44] finish_time,
  // [123:84] makespan, [127:124] zero
  output logic [efs_pkg::OutDataBits-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tuser_o  // saturated
);

  localparam int unsigned TB = efs_pkg::TimeBits;
  localparam int unsigned IB = efs_pkg::IdxBits;
  localparam int unsigned CB = efs_pkg::CntBits;

  efs_pkg::state_e state_q, state_d;

  logic [efs_pkg::CfgBits-1:0]   cfg_q;
  logic [efs_pkg::RateBits-1:0]  rate_q  [efs_pkg::MaxServers];
  logic [TB-1:0]                 free_q  [efs_pkg::MaxServers];
  logic [efs_pkg::MaxServers-1:0] valid_q;
  logic [TB-1:0]                 makespan_q;

  logic [CB-1:0]                 scan_q;
  logic [IB-1:0]                 best_q;
  logic [TB-1:0]                 best_time_q;
  logic [efs_pkg::ItemBits-1:0]  count_q;
  logic [efs_pkg::WorkBits-1:0]  work_q;
  logic [TB-1:0]                 finish_q;
  logic                          sat_q;

  logic                          out_valid_q;
  logic [IB-1:0]                 out_server_q;
  logic [TB-1:0]                 out_start_q, out_finish_q, out_make_q;
  logic                          out_sat_q;

  logic [CB-1:0]                 active_n;
  logic [TB-1:0]                 scan_time, zero_time;
  logic [TB:0]                   sum;
  logic                          in_xfer, out_free;
  efs_pkg::req_e                 req;
  logic [IB-1:0]                 in_idx;
  logic [efs_pkg::RateBits-1:0]  in_rate;
  logic [efs_pkg::ItemBits-1:0]  in_count;

  assign req      = efs_pkg::req_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[3:0];
  assign in_rate  = s_axis_tdata_i[11:4];
  assign in_count = s_axis_tdata_i[19:12];
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // clamp the configured count to 1..MaxServers
  always_comb begin
    if (cfg_q == '0) begin
      active_n = CB'(1);
    end else if (CB'(cfg_q) > CB'(efs_pkg::MaxServers)) begin
      active_n = CB'(efs_pkg::MaxServers);
    end else begin
      active_n = CB'(cfg_q);
    end
  end

  // entries not written since the last clear read as zero
  assign scan_time = valid_q[scan_q[IB-1:0]] ? free_q[scan_q[IB-1:0]] : '0;
  assign zero_time = valid_q[0] ? free_q[0] : '0;
  assign sum       = {1'b0, best_time_q} + {{(TB + 1 - efs_pkg::WorkBits){1'b0}}, work_q};

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      efs_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i && req == efs_pkg::REQ_JOB) begin
          state_d = efs_pkg::ST_SCAN;
        end
      end
      efs_pkg::ST_SCAN: begin
        if (scan_q >= active_n) begin
          state_d = efs_pkg::ST_MUL;
        end
      end
      efs_pkg::ST_MUL:    state_d = efs_pkg::ST_ADD;
      efs_pkg::ST_ADD:    state_d = efs_pkg::ST_UPDATE;
      efs_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_d = efs_pkg::ST_IDLE;
        end
      end
      default:            state_d = efs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efs_pkg::ST_IDLE;
      cfg_q       <= efs_pkg::CfgBits'(1);
      valid_q     <= '0;
      makespan_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (in_xfer && req == efs_pkg::REQ_CLEAR) begin
        valid_q    <= '0;
        makespan_q <= '0;
      end
      if (state_q == efs_pkg::ST_UPDATE && out_free) begin
        valid_q[best_q] <= 1'b1;
        out_valid_q     <= 1'b1;
        if (finish_q > makespan_q) begin
          makespan_q <= finish_q;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer && req == efs_pkg::REQ_LOAD) begin
      rate_q[in_idx] <= in_rate;
    end
    if (in_xfer && req == efs_pkg::REQ_JOB) begin
      count_q     <= in_count;
      best_q      <= '0;
      best_time_q <= zero_time;
      scan_q      <= CB'(1);
    end
    if (state_q == efs_pkg::ST_SCAN && scan_q < active_n) begin
      // strict compare keeps the lowest index on ties
      if (scan_time < best_time_q) begin
        best_q      <= scan_q[IB-1:0];
        best_time_q <= scan_time;
      end
      scan_q <= scan_q + CB'(1);
    end
    if (state_q == efs_pkg::ST_MUL) begin
      work_q <= rate_q[best_q] * count_q;
    end
    if (state_q == efs_pkg::ST_ADD) begin
      // clip at the largest time on carry out
      sat_q    <= sum[TB];
      finish_q <= sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
    end
    if (state_q == efs_pkg::ST_UPDATE && out_free) begin
      free_q[best_q] <= finish_q;
      out_server_q   <= best_q;
      out_start_q    <= best_time_q;
      out_finish_q   <= finish_q;
      out_make_q     <= (finish_q > makespan_q) ? finish_q : makespan_q;
      out_sat_q      <= sat_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_make_q, out_finish_q, out_start_q, out_server_q};
  assign m_axis_tuser_o  = out_sat_q;

endmodule

// ----- test/earliest_free_server_scheduler_tb.sv -----
// Self-checking testbench for the earliest-free server scheduler.
// Drives rate loads, jobs and clears over the input stream and checks every job
// result against a built-in predictor or a fixed table entry; depends on efs_pkg and the scheduler RTL.
module earliest_free_server_scheduler_tb;

  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 2 * (efs_pkg::MaxServers + 4);
  localparam int unsigned PhaseItems  = 178;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned DirRows     = 25;

  typedef struct packed {
    logic [efs_pkg::IdxBits-1:0]  server;
    logic [efs_pkg::TimeBits-1:0] start_t;
    logic [efs_pkg::TimeBits-1:0] finish_t;
    logic [efs_pkg::TimeBits-1:0] span_t;
    logic                         sat;
  } job_result_t;

  typedef struct packed {
    efs_pkg::req_e                req;
    logic [efs_pkg::IdxBits-1:0]  idx;
    logic [efs_pkg::RateBits-1:0] rate;
    logic [efs_pkg::ItemBits-1:0] cnt;
    logic                         fixed;
    job_result_t                  res;
  } stim_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [efs_pkg::CfgBits-1:0]     cfg_wdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [efs_pkg::InDataBits-1:0]  s_tdata;
  efs_pkg::req_e                   s_tuser;
  logic                            m_tvalid;
  logic                            m_ready;
  logic [efs_pkg::OutDataBits-1:0] m_tdata;
  logic                            m_tuser;

  // predictor state
  logic [efs_pkg::RateBits-1:0] rate_tbl [efs_pkg::MaxServers];
  logic [efs_pkg::TimeBits-1:0] free_tbl [efs_pkg::MaxServers];
  logic [efs_pkg::TimeBits-1:0] span_reg;
  logic [efs_pkg::CfgBits-1:0]  srv_count;

  job_result_t pending_jobs [$];
  logic        pend_fixed;
  job_result_t pend_res;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  stim_row_t dir_tab [DirRows] = '{
    '{efs_pkg::REQ_LOAD,  4'd0,  8'd255, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd1,  8'd0,   8'd255, 1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd2,  8'd1,   8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd3,  8'd7,   8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd4,  8'd16,  8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd5,  8'd31,  8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd6,  8'd64,  8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd7,  8'd100, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd8,  8'd128, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd9,  8'd170, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd10, 8'd200, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd11, 8'd85,  8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd12, 8'd254, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd13, 8'd3,   8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd14, 8'd42,  8'd0,   1'b0, '0},
    '{efs_pkg::REQ_LOAD,  4'd15, 8'd255, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_JOB,   4'd0,  8'd0,   8'd255, 1'b1,
      '{4'd0, 40'd0, 40'd65025, 40'd65025, 1'b0}},
    '{efs_pkg::REQ_JOB,   4'd15, 8'd255, 8'd0,   1'b1,
      '{4'd0, 40'd65025, 40'd65025, 40'd65025, 1'b0}},
    '{efs_pkg::REQ_NONE,  4'd15, 8'd255, 8'd255, 1'b0, '0},
    '{efs_pkg::REQ_CLEAR, 4'd0,  8'd0,   8'd0,   1'b0, '0},
    '{efs_pkg::REQ_JOB,   4'd0,  8'd0,   8'd1,   1'b1,
      '{4'd0, 40'd0, 40'd255, 40'd255, 1'b0}},
    '{efs_pkg::REQ_LOAD,  4'd0,  8'd0,   8'd0,   1'b0, '0},
    '{efs_pkg::REQ_JOB,   4'd0,  8'd0,   8'd255, 1'b1,
      '{4'd0, 40'd255, 40'd255, 40'd255, 1'b0}},
    '{efs_pkg::REQ_LOAD,  4'd0,  8'd170, 8'd0,   1'b0, '0},
    '{efs_pkg::REQ_JOB,   4'd0,  8'd0,   8'd85,  1'b0, '0}
  };

  // extremes of the register plus values outside the legal range
  logic [efs_pkg::CfgBits-1:0] phase_count [NumPhases] = '{5'd16, 5'd0, 5'd31, 5'd3,
                                                           5'd17, 5'd1, 5'd8, 5'd16};

  earliest_free_server_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the predictor; returns 1 when a job result is due.
  function automatic bit apply_request(efs_pkg::req_e r, logic [efs_pkg::IdxBits-1:0] idx,
                                       logic [efs_pkg::RateBits-1:0] rate,
                                       logic [efs_pkg::ItemBits-1:0] cnt,
                                       output job_result_t res);
    int unsigned n;
    int unsigned best;
    logic [63:0] work;
    logic [63:0] start;
    logic [63:0] finish;
    logic [63:0] tmax;
    res = '0;
    case (r)
      efs_pkg::REQ_LOAD: begin
        rate_tbl[idx] = rate;
        return 1'b0;
      end
      efs_pkg::REQ_CLEAR: begin
        for (int unsigned i = 0; i < efs_pkg::MaxServers; i++) free_tbl[i] = '0;
        span_reg = '0;
        return 1'b0;
      end
      efs_pkg::REQ_JOB: begin
        n = (srv_count == 0) ? 1 :
            ((srv_count > efs_pkg::MaxServers) ? efs_pkg::MaxServers : srv_count);
        best = 0;
        for (int unsigned i = 1; i < n; i++) begin
          if (free_tbl[i] < free_tbl[best]) best = i;
        end
        tmax = {{(64 - efs_pkg::TimeBits){1'b0}}, {efs_pkg::TimeBits{1'b1}}};
        start = 64'(free_tbl[best]);
        work = 64'(rate_tbl[best]) * 64'(cnt);
        res.sat = (work > tmax - start);
        finish = res.sat ? tmax : start + work;
        free_tbl[best] = finish[efs_pkg::TimeBits-1:0];
        if (free_tbl[best] > span_reg) span_reg = free_tbl[best];
        res.server = best[efs_pkg::IdxBits-1:0];
        res.start_t = start[efs_pkg::TimeBits-1:0];
        res.finish_t = finish[efs_pkg::TimeBits-1:0];
        res.span_t = span_reg;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // input side: predict on every accepted transfer
  always @(posedge clk_i) begin
    job_result_t res;
    if (rst_n && s_tvalid && s_tready) begin
      if (apply_request(s_tuser, s_tdata[3:0], s_tdata[11:4], s_tdata[19:12], res)) begin
        pending_jobs.push_back(pend_fixed ? pend_res : res);
      end
    end
  end

  // output side: compare against the oldest expectation
  always @(posedge clk_i) begin
    job_result_t want;
    if (rst_n && m_tvalid && m_ready) begin
      if (pending_jobs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
        mismatch_count++;
      end else begin
        want = pending_jobs.pop_front();
        check_field("chosen_server", 64'(want.server), 64'(m_tdata[3:0]));
        check_field("start_time", 64'(want.start_t), 64'(m_tdata[43:4]));
        check_field("finish_time", 64'(want.finish_t), 64'(m_tdata[83:44]));
        check_field("makespan", 64'(want.span_t), 64'(m_tdata[123:84]));
        check_field("saturated", 64'(want.sat), 64'(m_tuser));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n) m_ready <= 1'b0;
    else m_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer or config write
  always @(posedge clk_i) begin
    if (!rst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(efs_pkg::req_e r, logic [efs_pkg::IdxBits-1:0] idx,
                              logic [efs_pkg::RateBits-1:0] rate,
                              logic [efs_pkg::ItemBits-1:0] cnt, logic fixed,
                              job_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r;
    s_tdata <= {4'b0, cnt, rate, idx};
    pend_fixed <= fixed;
    pend_res <= res;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (pending_jobs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    efs_pkg::req_e                r;
    logic [efs_pkg::ItemBits-1:0] cnt;
    int unsigned                  sent;
    int unsigned                  pick;
    for (int unsigned i = 0; i < efs_pkg::MaxServers; i++) begin
      rate_tbl[i] = '0;
      free_tbl[i] = '0;
    end
    span_reg = '0;
    srv_count = 5'd1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = efs_pkg::REQ_NONE;
    pend_fixed = 1'b0;
    pend_res = '0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed table, one active server; loads every rate before any wider use
    for (int unsigned k = 0; k < DirRows; k++) begin
      send_request(dir_tab[k].req, dir_tab[k].idx, dir_tab[k].rate, dir_tab[k].cnt,
                   dir_tab[k].fixed, dir_tab[k].res);
    end
    drain_and_settle();

    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      cfg_we <= 1'b1;
      cfg_wdata <= phase_count[p];
      @(posedge clk_i);
      cfg_we <= 1'b0;
      srv_count = phase_count[p];

      sent = 0;
      while (sent < PhaseItems) begin
        pick = $urandom_range(99);
        if (pick < 60) r = efs_pkg::REQ_JOB;
        else if (pick < 84) r = efs_pkg::REQ_LOAD;
        else if (pick < 92) r = efs_pkg::REQ_CLEAR;
        else r = efs_pkg::REQ_NONE;
        // bias some counts to the extremes
        case ($urandom_range(7))
          0: cnt = '0;
          1: cnt = '1;
          2: cnt = efs_pkg::ItemBits'($urandom_range(3));
          default: cnt = efs_pkg::ItemBits'($urandom);
        endcase
        send_request(r, efs_pkg::IdxBits'($urandom), efs_pkg::RateBits'($urandom), cnt,
                     1'b0, '0);
        sent++;
      end
      drain_and_settle();
    end

    if (mismatch_count == 0 && pending_jobs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
